>>> src/lkvc_pkg.sv
package lkvc_pkg;

   localparam int MAX_ENTRIES_DEF = 16;
   localparam int DATA_W          = 32;
   localparam int CAP_W           = 5;

   localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
   localparam logic [DATA_W-1:0] MISS_VALUE = '1;   // -1 on a miss

   typedef enum logic [0:0] {
      OP_GET = 1'b0,
      OP_SET = 1'b1
   } op_type;

endpackage

>>> src/lru_key_value_cache_top.sv
// Fully associative key/value cache with least-recently-used replacement.
// A request carries an opcode in req_tuser (0 = get, 1 = set) and a key and
// value in req_tdata. A get returns one response: rsp_tuser = 1 with the stored
// value on a hit, rsp_tuser = 0 with -1 on a miss; a hit makes the entry the
// most recent. A set gives no response; it overwrites a present key or inserts
// a new pair in the lowest free slot, evicting the least recent entry first
// when occupancy has reached the capacity. Capacity comes from csr_wdata
// (reset 16), is taken as 1 when written as 0 and saturates at MAX_ENTRIES;
// write it only while no request is in flight. Each request does its work in
// a single stage between the input register and the response
// register: the parallel key compare, the recency-rank update of all entries
// and the free-slot search all fit in that one pass, so a new request is taken
// every cycle unless a get waits on a held response. A get's response is
// valid once it has passed the input register and the response register.
// While a response waits, a set still passes the stage; a get holds in the
// input register, with req_tready low, until the waiting response is taken.
module lru_key_value_cache_top #(
   parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request: tdata = {store_value, lookup_key}; tuser = opcode
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [2*lkvc_pkg::DATA_W-1:0]    req_tdata,
   input  logic                             req_tuser,
   // response: tdata = read_value; tuser = hit
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lkvc_pkg::DATA_W-1:0]      rsp_tdata,
   output logic                             rsp_tuser,
   // capacity register write
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [lkvc_pkg::CAP_W-1:0]       csr_wdata
);
   import lkvc_pkg::*;

   localparam int RANK_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int OCC_W  = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;

   // configuration
   logic [CAP_W-1:0] cap_ff;

   // input stage
   logic              stg_valid_ff, stg_valid_in;
   op_type            stg_op_ff;
   logic [DATA_W-1:0] stg_key_ff, stg_val_ff;

   // cache state
   logic [DATA_W-1:0]      key_ff  [MAX_ENTRIES];
   logic [DATA_W-1:0]      key_in  [MAX_ENTRIES];
   logic [DATA_W-1:0]      val_ff  [MAX_ENTRIES];
   logic [DATA_W-1:0]      val_in  [MAX_ENTRIES];
   logic [RANK_W-1:0]      rank_ff [MAX_ENTRIES];
   logic [RANK_W-1:0]      rank_in [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;
   logic [OCC_W-1:0]       occ_ff, occ_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_hit_ff, rsp_hit_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // datapath
   logic                   req_acc, out_free, stg_go;
   logic [MAX_ENTRIES-1:0] match, victim, valid_post, free_slots, slot;
   logic                   hit_any, do_evict;
   logic [DATA_W-1:0]      hit_val;
   logic [RANK_W-1:0]      hit_rank, oldest_rank;
   logic [CMP_W-1:0]       cap_eff;

   assign csr_ready = 1'b1;

   // handshake: the stage moves on unless a get waits on a full response reg
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign stg_go     = stg_valid_ff && (stg_op_ff == OP_SET || out_free);
   assign req_tready = !stg_valid_ff || stg_go;
   assign req_acc    = req_tvalid && req_tready;

   always_comb begin
      stg_valid_in = stg_valid_ff;
      if (req_acc) begin
         stg_valid_in = 1'b1;
      end else if (stg_go) begin
         stg_valid_in = 1'b0;
      end
   end

   // clamp capacity into 1..MAX_ENTRIES
   always_comb begin
      cap_eff = CMP_W'(cap_ff);
      if (cap_ff == '0) begin
         cap_eff = CMP_W'(1);
      end else if (cap_eff > CMP_W'(MAX_ENTRIES)) begin
         cap_eff = CMP_W'(MAX_ENTRIES);
      end
   end

   // lookup, victim and free slot
   always_comb begin
      hit_val     = '0;
      hit_rank    = '0;
      oldest_rank = RANK_W'(occ_ff - 1'b1);
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         match[i]  = valid_ff[i] && (key_ff[i] == stg_key_ff);
         // valid ranks are always a permutation of 0..occ-1
         victim[i] = valid_ff[i] && (rank_ff[i] == oldest_rank);
         hit_val   = hit_val  | (match[i] ? val_ff[i]  : '0);
         hit_rank  = hit_rank | (match[i] ? rank_ff[i] : '0);
      end
      hit_any    = |match;
      do_evict   = (stg_op_ff == OP_SET) && !hit_any && (CMP_W'(occ_ff) >= cap_eff);
      valid_post = do_evict ? (valid_ff & ~victim) : valid_ff;
      free_slots = ~valid_post;
      slot       = free_slots & (~free_slots + 1'b1);   // lowest free entry
   end

   // state update
   always_comb begin
      key_in   = key_ff;
      val_in   = val_ff;
      rank_in  = rank_ff;
      valid_in = valid_ff;
      occ_in   = occ_ff;
      if (stg_go) begin
         if (hit_any) begin
            // touch: newer entries age by one, hit entry becomes newest
            for (int i = 0; i < MAX_ENTRIES; i++) begin
               if (match[i]) begin
                  rank_in[i] = '0;
                  if (stg_op_ff == OP_SET) begin
                     val_in[i] = stg_val_ff;
                  end
               end else if (valid_ff[i] && rank_ff[i] < hit_rank) begin
                  rank_in[i] = rank_ff[i] + 1'b1;
               end
            end
         end else if (stg_op_ff == OP_SET) begin
            valid_in = valid_post | slot;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
               if (slot[i]) begin
                  key_in[i]  = stg_key_ff;
                  val_in[i]  = stg_val_ff;
                  rank_in[i] = '0;
               end else if (valid_post[i]) begin
                  rank_in[i] = rank_ff[i] + 1'b1;
               end
            end
            occ_in = occ_ff - OCC_W'(do_evict) + OCC_W'(|slot);
         end
      end
   end

   // response
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_data_in  = rsp_data_ff;
      if (stg_go && stg_op_ff == OP_GET) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = hit_any;
         rsp_data_in  = hit_any ? hit_val : MISS_VALUE;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         stg_valid_ff <= 1'b0;
         valid_ff     <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_wdata;
         end
         stg_valid_ff <= stg_valid_in;
         valid_ff     <= valid_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
         rank_ff      <= rank_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_acc) begin
         stg_op_ff  <= op_type'(req_tuser);
         stg_key_ff <= req_tdata[DATA_W-1:0];
         stg_val_ff <= req_tdata[2*DATA_W-1:DATA_W];
      end
      key_ff      <= key_in;
      val_ff      <= val_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> src/lkvc_checker.sv
module lkvc_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tvalid,
   input logic                         req_tready,
   input logic                         req_tuser,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [lkvc_pkg::DATA_W-1:0]  rsp_tdata,
   input logic                         rsp_tuser
);
   import lkvc_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // a miss always reads as -1
   a_miss_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == MISS_VALUE)
      else $error("miss response without -1");

   // no response straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a lone set into an idle block gives no response after it passes the stage
   a_set_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == OP_SET && !rsp_tvalid
      ##1 !(req_tvalid && req_tready) && !rsp_tvalid |=> !rsp_tvalid)
      else $error("set produced a response");

endmodule

bind lru_key_value_cache_top lkvc_checker u_lkvc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
